// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define LMSB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LMSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/lmsb_pkg.sv
`timescale 1ns / 1ps

package lmsb_pkg;

  localparam int ROWS   = 8;
  localparam int ROW_W  = 3;
  localparam int PIX_W  = 8;
  localparam int OFS_W  = 5;
  localparam int MODE_W = 2;
  localparam int CFG_W  = 1;

  localparam logic [PIX_W-1:0] PB_BASE = 8'h60;
  localparam logic [PIX_W-1:0] PC_BASE = 8'hB4;
  localparam logic [PIX_W-1:0] PD_BASE = 8'h09;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_COMMIT = 2'd1,
    MODE_TICK   = 2'd2
  } mode_t;

  typedef enum logic [CFG_W-1:0] {
    CFG_X_OFFSET = 1'b0,
    CFG_Y_OFFSET = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BLIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic stage_wr;
    logic blit_clr;
    logic blit_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic blit_last;
    logic out_free;
  } status_t;

endpackage

// File: hdl/lmsb_req_if.sv
`timescale 1ns / 1ps

interface lmsb_req_if
  import lmsb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ROW_W-1:0]  sprite_index;
  logic [PIX_W-1:0]  sprite_data;

  modport source (output valid, output mode, output sprite_index, output sprite_data,
                  input ready);
  modport sink (input valid, input mode, input sprite_index, input sprite_data,
                output ready);
endinterface

// File: hdl/lmsb_scan_if.sv
`timescale 1ns / 1ps

interface lmsb_scan_if
  import lmsb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] scan_row;
  logic [PIX_W-1:0] port_b_level;
  logic [PIX_W-1:0] port_c_level;
  logic [PIX_W-1:0] port_d_level;

  modport source (output valid, output scan_row, output port_b_level,
                  output port_c_level, output port_d_level, input ready);
  modport sink (input valid, input scan_row, input port_b_level,
                input port_c_level, input port_d_level, output ready);
endinterface

// File: hdl/led_matrix_scan_blit.sv
`timescale 1ns / 1ps
// 8x8 LED matrix row-scan driver with a sprite staging buffer.
// Requests arrive on req (valid/ready); mode selects load, commit or tick.
//   load:   writes sprite_data into staging row sprite_index.
//   commit: copies staging into screen memory with the x/y offsets,
//           one screen row per cycle through a single staging read and
//           shift unit after the accepting cycle.
//   tick:   advances the scan row and presents scan_row plus the port
//           B/C/D pin patterns on scan; it passes through the S_EMIT state,
//           which waits until the result register is free, then registers the result.
//   mode 3 is taken and dropped.
// Load and commit produce no result. Only ticks produce one result each.
// Configuration (cfg_we, cfg_index, cfg_data) sets x_offset (index 0) and
// y_offset (index 1); write it only while no request is in flight.
// Reset clears staging and screen memory, the offsets and the scan row,
// so the first tick drives row 1.
// A result waits in an output register until scan.ready; loads and commits
// are still accepted meanwhile, a further tick holds req.ready low until
// the waiting result is taken.

module led_matrix_scan_blit
  import lmsb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_index,
  input  logic [OFS_W-1:0] cfg_data,
  lmsb_req_if.sink         req,
  lmsb_scan_if.source      scan
);

  cmd_t    cmd;
  status_t status;

  lmsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_mode  (req.mode),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lmsb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sprite_index (req.sprite_index),
    .sprite_data  (req.sprite_data),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (scan.valid),
    .out_ready    (scan.ready),
    .scan_row     (scan.scan_row),
    .port_b_level (scan.port_b_level),
    .port_c_level (scan.port_c_level),
    .port_d_level (scan.port_d_level)
  );

endmodule

// File: hdl/lmsb_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmsb_ctrl
  import lmsb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  status_t           status,
  output cmd_t              cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            MODE_LOAD: begin
              cmd.stage_wr = 1'b1;
            end
            MODE_COMMIT: begin
              cmd.blit_clr = 1'b1;
              state_next   = S_BLIT;
            end
            MODE_TICK: begin
              state_next = S_EMIT;
            end
            default: begin
              // unused mode: drop the request
            end
          endcase
        end
      end
      S_BLIT: begin
        cmd.blit_step = 1'b1;
        if (status.blit_last) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        // hold the tick until the result register is free
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `LMSB_ASSERT(a_commit_starts_blit, clk, rst, in_valid && in_ready && in_mode == MODE_COMMIT |=> state == S_BLIT, "commit request did not start a blit")
  `LMSB_ASSERT(a_blit_ends, clk, rst, cmd.blit_step && status.blit_last |=> state == S_IDLE, "blit ran past the last row")

endmodule

// File: hdl/lmsb_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmsb_datapath
  import lmsb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [OFS_W-1:0]  cfg_data,
  input  logic [ROW_W-1:0]  sprite_index,
  input  logic [PIX_W-1:0]  sprite_data,
  input  cmd_t              cmd,
  output status_t           status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ROW_W-1:0]  scan_row,
  output logic [PIX_W-1:0]  port_b_level,
  output logic [PIX_W-1:0]  port_c_level,
  output logic [PIX_W-1:0]  port_d_level
);

  logic [OFS_W-1:0] x_ofs;
  logic [OFS_W-1:0] y_ofs;
  logic [PIX_W-1:0] staging [ROWS];
  logic [PIX_W-1:0] screen [ROWS];
  logic [ROW_W-1:0] blit_cnt;
  logic [ROW_W-1:0] cur_row;

  logic signed [OFS_W:0] src;
  logic [PIX_W-1:0]      src_row;
  logic [OFS_W-1:0]      left_amt;
  logic [PIX_W-1:0]      blit_row;
  logic [ROW_W-1:0]      row_next;
  logic [PIX_W-1:0]      col;
  logic [PIX_W-1:0]      pb;
  logic [PIX_W-1:0]      pc;
  logic [PIX_W-1:0]      pd;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_ofs <= '0;
      y_ofs <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_OFFSET: x_ofs <= cfg_data;
        CFG_Y_OFFSET: y_ofs <= cfg_data;
        default: ;
      endcase
    end
  end

  // Source row for the current blit step; outside 0..7 reads as blank.
  always_comb begin
    src      = $signed({3'b000, blit_cnt}) - $signed({y_ofs[OFS_W-1], y_ofs});
    src_row  = (src[OFS_W:ROW_W] == '0) ? staging[src[ROW_W-1:0]] : '0;
    left_amt = OFS_W'(-x_ofs);
    if (x_ofs[OFS_W-1]) begin
      blit_row = src_row << left_amt;
    end else begin
      blit_row = src_row >> x_ofs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        staging[i] <= '0;
        screen[i]  <= '0;
      end
    end else begin
      if (cmd.stage_wr) begin
        staging[sprite_index] <= sprite_data;
      end
      if (cmd.blit_step) begin
        screen[blit_cnt] <= blit_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blit_cnt <= '0;
    end else if (cmd.blit_clr) begin
      blit_cnt <= '0;
    end else if (cmd.blit_step) begin
      blit_cnt <= blit_cnt + 3'd1;
    end
  end

  assign status.blit_last = (blit_cnt == ROW_W'(ROWS - 1));
  assign status.out_free  = !out_valid || out_ready;

  // Port patterns for the next row: clear lit column pins, set the row select.
  always_comb begin
    row_next = cur_row + 3'd1;
    col      = screen[row_next];
    pb       = PB_BASE;
    pc       = PC_BASE;
    pd       = PD_BASE;
    if (col[7]) pc[2] = 1'b0;
    if (col[6]) pc[7] = 1'b0;
    if (col[5]) pc[4] = 1'b0;
    if (col[4]) pb[5] = 1'b0;
    if (col[3]) pd[3] = 1'b0;
    if (col[2]) pc[5] = 1'b0;
    if (col[1]) pb[6] = 1'b0;
    if (col[0]) pd[0] = 1'b0;
    unique case (row_next)
      3'd0:    pd[4] = 1'b1;
      3'd1:    pc[0] = 1'b1;
      3'd2:    pc[1] = 1'b1;
      3'd3:    pd[1] = 1'b1;
      3'd4:    pc[3] = 1'b1;
      3'd5:    pd[2] = 1'b1;
      3'd6:    pb[7] = 1'b1;
      default: pd[5] = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      cur_row   <= row_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      scan_row     <= row_next;
      port_b_level <= pb;
      port_c_level <= pc;
      port_d_level <= pd;
    end
  end

  `LMSB_ASSERT(a_emit_into_free_slot, clk, rst, cmd.emit |-> (!out_valid || out_ready), "result register overwritten before it was taken")
  `LMSB_ASSERT(a_emit_advances_row, clk, rst, cmd.emit |=> out_valid && (scan_row == $past(cur_row) + 3'd1), "scan row did not advance by one")
  `LMSB_ASSERT_ALWAYS(a_one_command, clk, $onehot0({cmd.stage_wr, cmd.blit_clr, cmd.blit_step, cmd.emit}), "more than one datapath command in a cycle")

endmodule

// File: dv/led_matrix_scan_blit_tb.sv
`timescale 1ns / 1ps

module led_matrix_scan_blit_tb;
  import lmsb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 140;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pb;
    logic [PIX_W-1:0] pc;
    logic [PIX_W-1:0] pd;
  } scan_t;

  class scan_pattern_board;
    logic [PIX_W-1:0] staging [ROWS];
    logic [PIX_W-1:0] screen [ROWS];
    logic [ROW_W-1:0] row;
    logic [OFS_W-1:0] x_ofs;
    logic [OFS_W-1:0] y_ofs;
    scan_t pending [$];
    int errors;

    function new();
      foreach (staging[i]) begin
        staging[i] = '0;
        screen[i] = '0;
      end
      row = '0;
      x_ofs = '0;
      y_ofs = '0;
      errors = 0;
    endfunction

    function void set_offset(cfg_reg_t idx, logic [OFS_W-1:0] val);
      if (idx == CFG_X_OFFSET) begin
        x_ofs = val;
      end else begin
        y_ofs = val;
      end
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [ROW_W-1:0] idx,
                               logic [PIX_W-1:0] data);
      int xs;
      int ys;
      int src;
      logic [PIX_W-1:0] col;
      scan_t res;
      xs = $signed(x_ofs);
      ys = $signed(y_ofs);
      case (mode)
        MODE_LOAD: begin
          staging[idx] = data;
        end
        MODE_COMMIT: begin
          for (int i = 0; i < ROWS; i++) begin
            src = i - ys;
            col = (src >= 0 && src < ROWS) ? staging[ROW_W'(src)] : '0;
            // shifts of 8 or more empty the row either way
            screen[ROW_W'(i)] = (xs >= 0) ? col >> xs : col << -xs;
          end
        end
        MODE_TICK: begin
          row = row + 1'b1;
          col = screen[row];
          res.row = row;
          res.pb = PB_BASE;
          res.pc = PC_BASE;
          res.pd = PD_BASE;
          // lit columns pull their pin low
          if (col[7]) res.pc[2] = 1'b0;
          if (col[6]) res.pc[7] = 1'b0;
          if (col[5]) res.pc[4] = 1'b0;
          if (col[4]) res.pb[5] = 1'b0;
          if (col[3]) res.pd[3] = 1'b0;
          if (col[2]) res.pc[5] = 1'b0;
          if (col[1]) res.pb[6] = 1'b0;
          if (col[0]) res.pd[0] = 1'b0;
          case (row)
            3'd0: res.pd[4] = 1'b1;
            3'd1: res.pc[0] = 1'b1;
            3'd2: res.pc[1] = 1'b1;
            3'd3: res.pd[1] = 1'b1;
            3'd4: res.pc[3] = 1'b1;
            3'd5: res.pd[2] = 1'b1;
            3'd6: res.pb[7] = 1'b1;
            default: res.pd[5] = 1'b1;
          endcase
          pending.push_back(res);
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_scan(scan_t got);
      scan_t want;
      if (pending.size() == 0) begin
        report($sformatf("scan row %0d arrived with nothing expected", got.row));
        return;
      end
      want = pending.pop_front();
      if (got.row != want.row)
        report($sformatf("scan_row %0d, want %0d", got.row, want.row));
      if (got.pb != want.pb)
        report($sformatf("row %0d port_b %02h, want %02h", want.row, got.pb, want.pb));
      if (got.pc != want.pc)
        report($sformatf("row %0d port_c %02h, want %02h", want.row, got.pc, want.pc));
      if (got.pd != want.pd)
        report($sformatf("row %0d port_d %02h, want %02h", want.row, got.pd, want.pd));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [OFS_W-1:0] cfg_data;
  int src_idle;
  int snk_idle;
  int stall_cycles;

  lmsb_req_if req_ch ();
  lmsb_scan_if scan_ch ();

  scan_pattern_board sb = new();

  led_matrix_scan_blit u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .scan(scan_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    scan_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  // check results before noting a request taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (scan_ch.valid && scan_ch.ready)
        sb.check_scan({scan_ch.scan_row, scan_ch.port_b_level,
                       scan_ch.port_c_level, scan_ch.port_d_level});
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.mode, req_ch.sprite_index, req_ch.sprite_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (scan_ch.valid && scan_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send(logic [MODE_W-1:0] m, logic [ROW_W-1:0] idx, logic [PIX_W-1:0] data);
    while ($urandom_range(99) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= m;
    req_ch.sprite_index <= idx;
    req_ch.sprite_data <= data;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_random();
    int r;
    logic [MODE_W-1:0] m;
    r = $urandom_range(99);
    if (r < 40) m = MODE_LOAD;
    else if (r < 55) m = MODE_COMMIT;
    else if (r < 95) m = MODE_TICK;
    else m = MODE_UNUSED;
    send(m, ROW_W'($urandom_range(ROWS - 1)), PIX_W'($urandom_range(255)));
  endtask

  // drop valid, drain all results, then let a trailing commit finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_offset(cfg_reg_t idx, logic [OFS_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_offset(idx, val);
    @(posedge clk);
  endtask

  initial begin
    logic [OFS_W-1:0] x_set [NUM_PHASES];
    logic [OFS_W-1:0] y_set [NUM_PHASES];
    x_set = '{5'd3, 5'd15, 5'h10, 5'd8, 5'h18, 5'd0, 5'd0, 5'h1F};
    y_set = '{5'h1E, 5'h10, 5'd15, 5'h18, 5'd8, 5'd0, 5'd0, 5'd1};
    x_set[5] = OFS_W'($urandom_range(31));
    y_set[5] = OFS_W'($urandom_range(31));
    x_set[6] = OFS_W'($urandom_range(31));
    y_set[6] = OFS_W'($urandom_range(31));
    src_idle = 33;
    snk_idle = 70;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_X_OFFSET;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_LOAD;
    req_ch.sprite_index <= '0;
    req_ch.sprite_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_offset(CFG_X_OFFSET, '0);
    write_offset(CFG_Y_OFFSET, '0);

    // blank display first, then one lit column per row and a full row
    send(MODE_TICK, 3'd5, 8'hA5);
    send(MODE_LOAD, 3'd0, 8'hFF);
    for (int i = 1; i < ROWS; i++) send(MODE_LOAD, ROW_W'(i), 8'h80 >> i);
    send(MODE_UNUSED, 3'd7, 8'hFF);
    send(MODE_COMMIT, 3'd2, 8'h00);
    for (int i = 0; i < ROWS; i++)
      send(MODE_TICK, ROW_W'($urandom_range(7)), PIX_W'($urandom_range(255)));
    send(MODE_LOAD, 3'd1, 8'h00);
    send(MODE_COMMIT, 3'd0, 8'h5A);
    send(MODE_TICK, 3'd7, 8'hFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      src_idle = (p < 3) ? 33 : (p < 6) ? 70 : 0;
      snk_idle = (p < 3) ? 70 : (p < 6) ? 33 : 0;
      settle();
      write_offset(CFG_X_OFFSET, x_set[p]);
      write_offset(CFG_Y_OFFSET, y_set[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) settle();
        send_random();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d scan results never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/lmsb_pkg.sv
hdl/lmsb_req_if.sv
hdl/lmsb_scan_if.sv
hdl/lmsb_ctrl.sv
hdl/lmsb_datapath.sv
hdl/led_matrix_scan_blit.sv
dv/led_matrix_scan_blit_tb.sv
